// ===== src/camera_jpeg_frame_extractor_defines.svh =====
// Assertion macros for the JPEG frame extractor.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef CAMERA_JPEG_FRAME_EXTRACTOR_DEFINES_SVH
`define CAMERA_JPEG_FRAME_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge.
`define CJFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at the next clock edge.
`define CJFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CJFE_ASSERT(lbl, prop, msg)

`define CJFE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/cjfe_pkg.sv =====
`timescale 1ns / 1ps

package cjfe_pkg;

  // Field and register widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SkipW   = 4;
  localparam int unsigned CountW  = 21;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 21;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSkipFrames = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxBytes   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgContinuous = 2'd2;

  // JPEG marker bytes
  localparam logic [ByteW-1:0] MarkerPrefix = 8'hFF;
  localparam logic [ByteW-1:0] MarkerSoi    = 8'hD8;
  localparam logic [ByteW-1:0] MarkerEoi    = 8'hD9;

  // Status codes carried by a status item
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SOI   = 2'd1,
    ST_NO_EOI   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // One result item
  typedef struct packed {
    logic             is_status;
    logic [ByteW-1:0] out_byte;
    logic             last;
    status_e          status_code;
  } res_t;

  // Push request toward the result queue
  typedef struct packed {
    logic [1:0] cnt;  // number of items pushed: 0, 1 or 2
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

// ===== src/camera_jpeg_frame_extractor.sv =====
`timescale 1ns / 1ps
// JPEG frame extractor for a parallel camera port.
// Input channel (valid/stall): one item per pixel clock sample (mode 0, with
// vsync, href and the data byte) or a start request (mode 1).
// Output channel (valid/stall): JPEG bytes from the FF D8 start marker through
// the FF D9 end marker (last set on the D9), or one status item (last set)
// when a frame has no start marker, no end marker, or overflows max_bytes.
// Config port: write enable, index (0 skip_frames, 1 max_bytes, 2 continuous)
// and data; write only while no item is in flight.
// An accepted item is registered, evaluated once the result queue has room for
// two results, and its results are pushed into the queue that feeds the output.
// Throughput: one item per cycle. The item holding the start marker yields
// two results; the result queue drains one per cycle, so a marker pair or a
// stalled receiver holds the input off once the queue lacks room for two.
// Reset: config registers return to their defaults, capture is idle and the queue is
// empty. A stalled receiver holds the head result steady; items keep flowing
// in until fewer than two queue slots are free, then in_stall_o rises.
module camera_jpeg_frame_extractor #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Config port
  input  logic                               cfg_we_i,
  input  logic [cjfe_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cjfe_pkg::CfgW-1:0]           cfg_wdata_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic                               vsync_i,
  input  logic                               href_i,
  input  logic [cjfe_pkg::ByteW-1:0]          pixel_byte_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               is_status_o,
  output logic [cjfe_pkg::ByteW-1:0]          out_byte_o,
  output logic                               last_o,
  output logic [1:0]                         status_code_o
);

  `include "camera_jpeg_frame_extractor_defines.svh"

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhWait = 2'd1;
  localparam logic [1:0] PhCapt = 2'd2;

  // Config registers
  logic [cjfe_pkg::SkipW-1:0]  skip_frames_q;
  logic [cjfe_pkg::CountW-1:0] max_bytes_q;
  logic                        continuous_q;

  // Input register
  logic                       in_valid_q, in_valid_d;
  logic                       mode_q, vsync_q, href_q;
  logic [cjfe_pkg::ByteW-1:0] byte_q;
  logic                       accept_in;
  logic                       proc;

  // Capture state
  logic [1:0]                  phase_q, phase_d;
  logic [cjfe_pkg::SkipW-1:0]  edges_left_q, edges_left_d;
  logic                        last_vsync_q, last_vsync_d;
  logic                        held_ff_q, held_ff_d;
  logic                        start_seen_q, start_seen_d;
  logic [cjfe_pkg::CountW-1:0] count_q, count_d;

  // Evaluation temporaries
  logic            rise, capt, arm_req, finish_req;
  cjfe_pkg::push_t push;
  logic            room2;
  cjfe_pkg::res_t  head;

  localparam cjfe_pkg::res_t ResNone = '{
    is_status: 1'b0, out_byte: '0, last: 1'b0, status_code: cjfe_pkg::ST_OK};

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_frames_q <= cjfe_pkg::SkipW'(3);
      max_bytes_q   <= cjfe_pkg::CountW'(65536);
      continuous_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cjfe_pkg::CfgSkipFrames: skip_frames_q <= cfg_wdata_i[cjfe_pkg::SkipW-1:0];
        cjfe_pkg::CfgMaxBytes:   max_bytes_q   <= cfg_wdata_i[cjfe_pkg::CountW-1:0];
        cjfe_pkg::CfgContinuous: continuous_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input handshake: hold the registered item until the queue has room
  assign proc       = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !room2;
  assign accept_in  = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept_in) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      mode_q  <= mode_i;
      vsync_q <= vsync_i;
      href_q  <= href_i;
      byte_q  <= pixel_byte_i;
    end
  end

  // Frame capture and marker search
  assign rise = vsync_q && !last_vsync_q;

  always_comb begin
    phase_d      = phase_q;
    edges_left_d = edges_left_q;
    last_vsync_d = last_vsync_q;
    held_ff_d    = held_ff_q;
    start_seen_d = start_seen_q;
    count_d      = count_q;
    capt         = 1'b0;
    arm_req      = 1'b0;
    finish_req   = 1'b0;
    push.cnt     = 2'd0;
    push.res0    = ResNone;
    push.res1    = ResNone;

    if (proc) begin
      if (mode_q) begin
        arm_req = 1'b1;
      end else begin
        last_vsync_d = vsync_q;
        capt = (phase_q == PhCapt);
        // Count vsync edges; the last one opens the frame on this sample
        if (phase_q == PhWait && rise) begin
          if (edges_left_q <= cjfe_pkg::SkipW'(1)) begin
            edges_left_d = '0;
            phase_d      = PhCapt;
            capt         = 1'b1;
          end else begin
            edges_left_d = edges_left_q - 1'b1;
          end
        end

        if (capt) begin
          if (!vsync_q) begin
            // Frame ended without an end marker
            push.cnt              = 2'd1;
            push.res0.is_status   = 1'b1;
            push.res0.last        = 1'b1;
            push.res0.status_code = start_seen_q ? cjfe_pkg::ST_NO_EOI
                                                 : cjfe_pkg::ST_NO_SOI;
            finish_req = 1'b1;
          end else if (href_q) begin
            if (count_q >= max_bytes_q) begin
              push.cnt              = 2'd1;
              push.res0.is_status   = 1'b1;
              push.res0.last        = 1'b1;
              push.res0.status_code = cjfe_pkg::ST_OVERFLOW;
              finish_req = 1'b1;
            end else begin
              count_d = count_q + 1'b1;
              if (!start_seen_q) begin
                if (held_ff_q && byte_q == cjfe_pkg::MarkerSoi) begin
                  // Emit the held FF along with the D8
                  push.cnt           = 2'd2;
                  push.res0.out_byte = cjfe_pkg::MarkerPrefix;
                  push.res1.out_byte = cjfe_pkg::MarkerSoi;
                  start_seen_d       = 1'b1;
                  held_ff_d          = 1'b0;
                end else begin
                  held_ff_d = (byte_q == cjfe_pkg::MarkerPrefix);
                end
              end else if (held_ff_q && byte_q == cjfe_pkg::MarkerEoi) begin
                push.cnt           = 2'd1;
                push.res0.out_byte = byte_q;
                push.res0.last     = 1'b1;
                finish_req         = 1'b1;
              end else begin
                push.cnt           = 2'd1;
                push.res0.out_byte = byte_q;
                held_ff_d          = (byte_q == cjfe_pkg::MarkerPrefix);
              end
            end
          end
        end
      end
    end

    // End of frame: re-arm or go idle
    if (finish_req) begin
      if (continuous_q) begin
        arm_req = 1'b1;
      end else begin
        phase_d = PhIdle;
      end
    end
    if (arm_req) begin
      phase_d      = PhWait;
      edges_left_d = skip_frames_q;
      held_ff_d    = 1'b0;
      start_seen_d = 1'b0;
      count_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      edges_left_q <= '0;
      last_vsync_q <= 1'b0;
      held_ff_q    <= 1'b0;
      start_seen_q <= 1'b0;
      count_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      edges_left_q <= edges_left_d;
      last_vsync_q <= last_vsync_d;
      held_ff_q    <= held_ff_d;
      start_seen_q <= start_seen_d;
      count_q      <= count_d;
    end
  end

  // Result queue
  cjfe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (head),
    .room2_o (room2)
  );

  assign is_status_o   = head.is_status;
  assign out_byte_o    = head.out_byte;
  assign last_o        = head.last;
  assign status_code_o = head.status_code;

  `CJFE_ASSERT(a_wait_clean,
               (phase_q != PhWait) || (!start_seen_q && !held_ff_q && count_q == '0),
               "waiting phase with stale frame state")
  `CJFE_ASSERT_NEXT(a_pair_sets_start, push.cnt == 2'd2, start_seen_q,
                    "marker pair emitted without start flag")
  `CJFE_ASSERT(a_stall_holds_item, !in_stall_o || in_valid_q,
               "input stalled with no held item")

endmodule

// ===== src/cjfe_fifo.sv =====
`timescale 1ns / 1ps

`include "camera_jpeg_frame_extractor_defines.svh"

// Result queue: up to two items in, one item out per cycle while pop_i is high.
module cjfe_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cjfe_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           valid_o,
  output cjfe_pkg::res_t data_o,
  output logic           room2_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  cjfe_pkg::res_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_ptr_nx;
  logic            pop;

  assign pop       = pop_i && (count_q != '0);
  assign wr_ptr_nx = ptr_inc(wr_ptr_q);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.cnt == 2'd1) begin
      wr_ptr_d = wr_ptr_nx;
    end else if (push_i.cnt == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_ptr_nx);
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign room2_o = (count_q <= CntW'(Depth - 2));

  `CJFE_ASSERT(a_fifo_no_over, count_q <= CntW'(Depth), "result queue over full")
  `CJFE_ASSERT(a_fifo_push_room, (push_i.cnt == 2'd0) || room2_o, "push without room")
  `CJFE_ASSERT_NEXT(a_fifo_pop_count, pop && (push_i.cnt == 2'd0),
                    count_q == $past(count_q) - 1'b1, "pop did not drain an item")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cjfe_pkg::*;

  // Item kinds on the input channel
  localparam logic ModeSample = 1'b0;
  localparam logic ModeStart  = 1'b1;

  // Capture phases of the frame tracker
  typedef enum logic [1:0] {
    CAP_IDLE = 2'd0,
    CAP_WAIT = 2'd1,
    CAP_GRAB = 2'd2
  } cap_phase_e;

  // Clock, reset and block ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgSkipFrames;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = ModeSample;
  logic               vsync = 1'b0;
  logic               href = 1'b0;
  logic [ByteW-1:0]   pixel_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               is_status;
  logic [ByteW-1:0]   out_byte;
  logic               res_last;
  logic [1:0]         status_code;

  // Shadow configuration and capture state
  logic [SkipW-1:0]  skip_cfg = 4'd3;
  logic [CountW-1:0] max_bytes_cfg = 21'd65536;
  logic              continuous_cfg = 1'b0;
  cap_phase_e        cap_phase = CAP_IDLE;
  logic [SkipW-1:0]  edges_to_go = '0;
  logic              prev_vsync = 1'b0;
  logic              ff_pending = 1'b0;
  logic              soi_found = 1'b0;
  logic [CountW-1:0] grabbed = '0;

  res_t       pending_results[$];
  logic [7:0] frame_bytes[$];
  int         error_count = 0;
  int         live_items = 0;
  int         hold_cycles = 0;
  bit         calm = 1'b0;

  camera_jpeg_frame_extractor dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .vsync_i       (vsync),
    .href_i        (href),
    .pixel_byte_i  (pixel_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .is_status_o   (is_status),
    .out_byte_o    (out_byte),
    .last_o        (res_last),
    .status_code_o (status_code)
  );

  always #5 clk = ~clk;

  // Random helpers
  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Marker bytes show up often so prefix/marker pairs form by chance too
  function automatic logic [7:0] biased_byte();
    case ($urandom_range(0, 7))
      0, 1: return MarkerPrefix;
      2: return MarkerSoi;
      3: return MarkerEoi;
      default: return rnd_byte();
    endcase
  endfunction

  // Wait before an item or result; zero in calm stretches
  function automatic int draw_gap();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 16);
    return 0;
  endfunction

  // Expected result builders
  function automatic res_t jpeg_res(logic [7:0] b, logic is_end);
    res_t r;
    r.is_status   = 1'b0;
    r.out_byte    = b;
    r.last        = is_end;
    r.status_code = ST_OK;
    return r;
  endfunction

  function automatic res_t status_res(status_e code);
    res_t r;
    r.is_status   = 1'b1;
    r.out_byte    = '0;
    r.last        = 1'b1;
    r.status_code = code;
    return r;
  endfunction

  // Frame tracker: arm, and end of frame
  function automatic void rearm_capture();
    cap_phase   = CAP_WAIT;
    edges_to_go = skip_cfg;
    ff_pending  = 1'b0;
    soi_found   = 1'b0;
    grabbed     = '0;
  endfunction

  function automatic void close_frame();
    if (continuous_cfg) rearm_capture();
    else cap_phase = CAP_IDLE;
  endfunction

  // Works out the JPEG bytes / status that one accepted item produces
  function automatic void predict_jpeg(logic m, logic v, logic h, logic [7:0] b);
    logic rising;
    live_items++;
    if (m == ModeStart) begin
      rearm_capture();
      return;
    end
    rising = v && !prev_vsync;
    prev_vsync = v;
    if (cap_phase == CAP_WAIT && rising) begin
      // a skip count of zero behaves like one
      if (edges_to_go <= 1) begin
        edges_to_go = '0;
        cap_phase = CAP_GRAB;
      end else begin
        edges_to_go = edges_to_go - 1'b1;
      end
    end
    if (cap_phase != CAP_GRAB) return;
    // vsync low closes the frame with a status
    if (!v) begin
      if (soi_found) pending_results.push_back(status_res(ST_NO_EOI));
      else pending_results.push_back(status_res(ST_NO_SOI));
      close_frame();
      return;
    end
    if (!h) return;
    if (grabbed >= max_bytes_cfg) begin
      pending_results.push_back(status_res(ST_OVERFLOW));
      close_frame();
      return;
    end
    grabbed = grabbed + 1'b1;
    if (!soi_found) begin
      // held prefix goes out together with the start marker
      if (ff_pending && b == MarkerSoi) begin
        pending_results.push_back(jpeg_res(MarkerPrefix, 1'b0));
        pending_results.push_back(jpeg_res(MarkerSoi, 1'b0));
        soi_found = 1'b1;
        ff_pending = 1'b0;
      end else begin
        ff_pending = (b == MarkerPrefix);
      end
    end else if (ff_pending && b == MarkerEoi) begin
      pending_results.push_back(jpeg_res(b, 1'b1));
      close_frame();
    end else begin
      pending_results.push_back(jpeg_res(b, 1'b0));
      ff_pending = (b == MarkerPrefix);
    end
  endfunction

  // Drive one item and hold it until accepted
  task automatic send_item(logic m, logic v, logic h, logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    vsync      <= v;
    href       <= h;
    pixel_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_jpeg(m, v, h, b);
  endtask

  task automatic send_start();
    send_item(ModeStart, rnd_bit(), rnd_bit(), rnd_byte());
  endtask

  // Wait until every expected result is out and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CfgSkipFrames: skip_cfg = val[SkipW-1:0];
      CfgMaxBytes:   max_bytes_cfg = val[CountW-1:0];
      CfgContinuous: continuous_cfg = val[0];
      default: ;
    endcase
  endtask

  function automatic int edges_needed();
    return (skip_cfg == 0) ? 1 : int'(skip_cfg);
  endfunction

  // Append bytes, never forming prefix + banned marker
  function automatic void add_noise(int count, logic [7:0] banned);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = biased_byte();
      if (b == banned && frame_bytes.size() != 0 && frame_bytes[$] == MarkerPrefix)
        b = 8'h5A;
      frame_bytes.push_back(b);
    end
  endfunction

  // Lead-in junk, optional start marker, body, then an optional end marker and trailer
  function automatic void build_frame(bit with_soi, bit with_eoi, int body_len);
    frame_bytes.delete();
    add_noise($urandom_range(0, 4), MarkerSoi);
    if (!with_soi) begin
      add_noise(body_len, MarkerSoi);
      return;
    end
    frame_bytes.push_back(MarkerPrefix);
    frame_bytes.push_back(MarkerSoi);
    add_noise(body_len, MarkerEoi);
    if (with_eoi) begin
      frame_bytes.push_back(MarkerPrefix);
      frame_bytes.push_back(MarkerEoi);
      add_noise($urandom_range(0, 3), 8'h00);
    end
  endfunction

  // Skipped frames, then frame_bytes on href with line gaps, then vsync low (or a start mid-frame)
  task automatic send_frame(int edges, bit abort_mid);
    int cut;
    cut = abort_mid ? frame_bytes.size() / 2 : frame_bytes.size();
    for (int e = 1; e < edges; e++) begin
      send_item(ModeSample, 1'b0, rnd_bit(), rnd_byte());
      repeat ($urandom_range(1, 2)) send_item(ModeSample, 1'b1, rnd_bit(), rnd_byte());
    end
    send_item(ModeSample, 1'b0, rnd_bit(), rnd_byte());
    if (cut == 0) send_item(ModeSample, 1'b1, 1'b0, rnd_byte());
    for (int i = 0; i < cut; i++) begin
      while ($urandom_range(0, 4) == 0) send_item(ModeSample, 1'b1, 1'b0, rnd_byte());
      send_item(ModeSample, 1'b1, 1'b1, frame_bytes[i]);
    end
    // a start in mid-frame aborts it silently
    if (abort_mid) send_start();
    else send_item(ModeSample, 1'b0, rnd_bit(), rnd_byte());
  endtask

  // Mismatch report: one line each
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    error_count++;
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none expected, byte", out_byte, 8'h00);
      return;
    end
    want = pending_results.pop_front();
    if (is_status !== want.is_status) report_mismatch("is_status", is_status, want.is_status);
    if (out_byte !== want.out_byte) report_mismatch("out_byte", out_byte, want.out_byte);
    if (res_last !== want.last) report_mismatch("last", res_last, want.last);
    if (status_code !== want.status_code)
      report_mismatch("status_code", status_code, want.status_code);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // Result receiver: random stalls, or a long hold-off when requested
  initial begin : result_sink
    int wait_cycles;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = draw_gap();
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Reset defaults: default vsync skip count, one short good image
  task automatic test_default_capture();
    send_item(ModeSample, 1'b1, 1'b0, rnd_byte());
    send_start();
    frame_bytes = {MarkerPrefix, MarkerSoi, MarkerPrefix, MarkerEoi};
    send_frame(3, 1'b0);
  endtask

  // Marker handling, href gating, re-arm, missing markers
  task automatic test_marker_cases();
    drain();
    write_reg(CfgSkipFrames, 1);
    write_reg(CfgContinuous, 1);
    send_start();
    send_item(ModeSample, 1'b0, 1'b0, rnd_byte());
    send_item(ModeSample, 1'b1, 1'b1, MarkerPrefix);
    send_item(ModeSample, 1'b1, 1'b1, MarkerSoi);
    send_item(ModeSample, 1'b1, 1'b1, MarkerPrefix);
    send_item(ModeSample, 1'b1, 1'b0, MarkerEoi);
    send_item(ModeSample, 1'b1, 1'b1, MarkerEoi);
    send_item(ModeSample, 1'b1, 1'b1, 8'h12);
    send_item(ModeSample, 1'b0, 1'b1, rnd_byte());
    // re-armed frame with no start marker
    send_item(ModeSample, 1'b1, 1'b1, MarkerPrefix);
    send_item(ModeSample, 1'b1, 1'b1, 8'h00);
    send_item(ModeSample, 1'b0, 1'b0, rnd_byte());
    // start marker but no end marker
    send_item(ModeSample, 1'b1, 1'b1, MarkerPrefix);
    send_item(ModeSample, 1'b1, 1'b1, MarkerSoi);
    send_item(ModeSample, 1'b1, 1'b1, MarkerPrefix);
    send_item(ModeSample, 1'b0, 1'b0, rnd_byte());
  endtask

  // Overflow at one and at zero bytes, zero skip count
  task automatic test_overflow_and_zero_skip();
    drain();
    write_reg(CfgMaxBytes, 1);
    send_item(ModeSample, 1'b1, 1'b1, MarkerPrefix);
    send_item(ModeSample, 1'b1, 1'b1, MarkerSoi);
    drain();
    write_reg(CfgMaxBytes, 0);
    send_item(ModeSample, 1'b0, 1'b0, rnd_byte());
    send_item(ModeSample, 1'b1, 1'b1, 8'hFF);
    drain();
    write_reg(CfgSkipFrames, 0);
    write_reg(CfgContinuous, 0);
    write_reg(CfgMaxBytes, 65536);
    send_start();
    send_item(ModeSample, 1'b0, 1'b0, rnd_byte());
    send_item(ModeSample, 1'b1, 1'b1, MarkerPrefix);
    send_item(ModeSample, 1'b1, 1'b1, MarkerSoi);
    send_item(ModeSample, 1'b1, 1'b1, MarkerPrefix);
    send_item(ModeSample, 1'b1, 1'b1, MarkerEoi);
  endtask

  // Largest skip count
  task automatic test_long_skip();
    drain();
    write_reg(CfgSkipFrames, 15);
    build_frame(1'b1, 1'b1, 4);
    send_start();
    send_frame(15, 1'b0);
  endtask

  // Receiver holds off while a long image streams in back to back
  task automatic test_backpressure();
    drain();
    write_reg(CfgSkipFrames, 1);
    write_reg(CfgMaxBytes, 1048576);
    calm = 1'b1;
    build_frame(1'b1, 1'b1, 50);
    hold_cycles = 150;
    send_start();
    send_frame(1, 1'b0);
    calm = 1'b0;
  endtask

  task automatic randomize_config();
    int pick;
    pick = $urandom_range(0, 9);
    write_reg(CfgSkipFrames, (pick == 0) ? 15 : (pick == 1) ? 0 : $urandom_range(1, 3));
    pick = $urandom_range(0, 9);
    if (pick == 0) write_reg(CfgMaxBytes, 1048576);
    else if (pick == 1) write_reg(CfgMaxBytes, 1);
    else if (pick < 4) write_reg(CfgMaxBytes, $urandom_range(2, 40));
    else write_reg(CfgMaxBytes, $urandom_range(64, 70000));
    write_reg(CfgContinuous, $urandom_range(0, 1));
  endtask

  // Mostly well-formed images with random content, some broken, some noise
  task automatic test_random_frames();
    int scene;
    int round_no;
    round_no = 0;
    while (live_items < 1300) begin
      if (round_no % 6 == 0) begin
        drain();
        randomize_config();
      end
      round_no++;
      calm = ($urandom_range(0, 3) == 0);
      scene = $urandom_range(0, 9);
      if (scene == 9) begin
        repeat ($urandom_range(4, 16))
          send_item(($urandom_range(0, 7) == 0) ? ModeStart : ModeSample,
                    rnd_bit(), rnd_bit(), rnd_byte());
      end else begin
        build_frame(scene != 7, scene != 6,
                    (scene == 8) ? $urandom_range(20, 60) : $urandom_range(1, 24));
        if (!continuous_cfg || $urandom_range(0, 1) == 1) send_start();
        send_frame(edges_needed(), $urandom_range(0, 9) == 0);
      end
    end
    calm = 1'b0;
  endtask

  initial begin : main_flow
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_capture();
    test_marker_cases();
    test_overflow_and_zero_skip();
    test_long_skip();
    test_backpressure();
    test_random_frames();
    drain();
    if (error_count == 0) begin
      $display("camera_jpeg_frame_extractor regression: pass");
    end else begin
      $display("camera_jpeg_frame_extractor regression: fail");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #5000000;
    $display("camera_jpeg_frame_extractor regression: fail");
    $finish;
  end

endmodule
